/* hw/rtl/assert_macros.svh */
// assertion macros used by the checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on the rising clock edge, off while reset is low
`define BSFF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen
`define BSFF_NEVER(lbl, clk, rst_n, cond, msg) \
	`BSFF_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

/* hw/rtl/bsff_pkg.sv */
// package for the bit store with find-first: sizes, codes, payload and control structs
// no dependencies
`default_nettype none

package bsff_pkg;

	localparam int DEPTH_BITS = 4096;
	localparam int WORD_BITS  = 64;
	localparam int NUM_WORDS  = (DEPTH_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int WORD_AW    = $clog2(NUM_WORDS);
	localparam int OFF_W      = $clog2(WORD_BITS);
	localparam int POS_W      = 12;
	localparam int LEN_W      = 13;
	localparam int GROUPS     = WORD_BITS / 8;
	localparam int GRP_W      = $clog2(GROUPS);

	// command codes
	localparam logic [2:0] CMD_READ   = 3'd0;
	localparam logic [2:0] CMD_WRITE  = 3'd1;
	localparam logic [2:0] CMD_APPEND = 3'd2;
	localparam logic [2:0] CMD_SETLEN = 3'd3;
	localparam logic [2:0] CMD_FIND   = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// result register updates
	localparam logic [2:0] RES_NONE  = 3'd0;
	localparam logic [2:0] RES_OK    = 3'd1;
	localparam logic [2:0] RES_RANGE = 3'd2;
	localparam logic [2:0] RES_FULL  = 3'd3;
	localparam logic [2:0] RES_READ  = 3'd4;
	localparam logic [2:0] RES_FIND  = 3'd5;

	typedef struct packed {
		logic [2:0]       command;
		logic [POS_W-1:0] position;
		logic             bit_value;
		logic [LEN_W-1:0] range_end;
		logic [LEN_W-1:0] new_length;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic             read_bit;
		logic             found;
		logic [POS_W-1:0] found_position;
		logic [LEN_W-1:0] current_length;
	} rsp_t;

	typedef struct packed {
		logic       cap;
		logic       rd_en;
		logic       addr_len;
		logic       wr_en;
		logic       len_set;
		logic       len_inc;
		logic       scan_start;
		logic       scan_en;
		logic [2:0] res_op;
		logic       out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] command;
		logic       pos_err;
		logic       full;
		logic       len_err;
		logic       find_err;
		logic       find_empty;
		logic       scan_done;
		logic       out_free;
	} dp_sts_t;

	// lowest set bit of a word: {any, index}, byte groups first, then bit in byte
	function automatic logic [OFF_W:0] first_set(input logic [WORD_BITS-1:0] w);
		logic [GROUPS-1:0] nz;
		logic [GRP_W-1:0]  bsel;
		logic [7:0]        b;
		logic [2:0]        isel;
		for (int i = 0; i < GROUPS; i++) begin
			nz[i] = |w[i*8 +: 8];
		end
		bsel = '0;
		for (int i = GROUPS - 1; i >= 0; i--) begin
			if (nz[i]) begin
				bsel = GRP_W'(i);
			end
		end
		b = w[bsel*8 +: 8];
		isel = '0;
		for (int i = 7; i >= 0; i--) begin
			if (b[i]) begin
				isel = 3'(i);
			end
		end
		return {|nz, bsel, isel};
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/bsff_ram.sv */
// generic single write port, single read port ram with registered read
// uses bsff_pkg for default sizes
`default_nettype none

module bsff_ram #(
	parameter int WIDTH = bsff_pkg::WORD_BITS,
	parameter int DEPTH = bsff_pkg::NUM_WORDS
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/bsff_ctrl.sv */
// controller state machine for the bit store: sequences decode, ram access, scan and result
// uses bsff_pkg for the command and status structs
`default_nettype none

module bsff_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output      logic              req_ready,
	input  wire bsff_pkg::dp_sts_t sts,
	output      bsff_pkg::dp_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_RDW  = 3'd2;
	localparam logic [2:0] S_WRB  = 3'd3;
	localparam logic [2:0] S_FIND = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		req_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.cap = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				state_d = S_FIN;
				case (sts.command)
					bsff_pkg::CMD_READ: begin
						if (sts.pos_err) begin
							cmd.res_op = bsff_pkg::RES_RANGE;
						end else begin
							cmd.rd_en = 1'b1;
							state_d   = S_RDW;
						end
					end
					bsff_pkg::CMD_WRITE: begin
						if (sts.pos_err) begin
							cmd.res_op = bsff_pkg::RES_RANGE;
						end else begin
							cmd.rd_en = 1'b1;
							state_d   = S_WRB;
						end
					end
					bsff_pkg::CMD_APPEND: begin
						if (sts.full) begin
							cmd.res_op = bsff_pkg::RES_FULL;
						end else begin
							cmd.rd_en    = 1'b1;
							cmd.addr_len = 1'b1;
							state_d      = S_WRB;
						end
					end
					bsff_pkg::CMD_SETLEN: begin
						if (sts.len_err) begin
							cmd.res_op = bsff_pkg::RES_RANGE;
						end else begin
							cmd.len_set = 1'b1;
							cmd.res_op  = bsff_pkg::RES_OK;
						end
					end
					bsff_pkg::CMD_FIND: begin
						if (sts.find_err) begin
							cmd.res_op = bsff_pkg::RES_RANGE;
						end else if (sts.find_empty) begin
							cmd.res_op = bsff_pkg::RES_OK;
						end else begin
							cmd.scan_start = 1'b1;
							state_d        = S_FIND;
						end
					end
					default: begin
						cmd.res_op = bsff_pkg::RES_RANGE;
					end
				endcase
			end
			S_RDW: begin
				cmd.res_op = bsff_pkg::RES_READ;
				state_d    = S_FIN;
			end
			S_WRB: begin
				// read-modify-write of the target word
				cmd.wr_en   = 1'b1;
				cmd.len_inc = (sts.command == bsff_pkg::CMD_APPEND);
				cmd.res_op  = bsff_pkg::RES_OK;
				state_d     = S_FIN;
			end
			S_FIND: begin
				cmd.scan_en = 1'b1;
				if (sts.scan_done) begin
					cmd.res_op = bsff_pkg::RES_FIND;
					state_d    = S_FIN;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/bsff_dp.sv */
// datapath for the bit store: request and length registers, word ram with valid bits,
// word scanner for find, result and output registers; uses bsff_pkg and bsff_ram
`default_nettype none

module bsff_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bsff_pkg::req_t    req,
	output      logic              rsp_valid,
	input  wire logic              rsp_ready,
	output      bsff_pkg::rsp_t    rsp,
	input  wire bsff_pkg::dp_cmd_t cmd,
	output      bsff_pkg::dp_sts_t sts
);

	localparam int WB    = bsff_pkg::WORD_BITS;
	localparam int AW    = bsff_pkg::WORD_AW;
	localparam int OW    = bsff_pkg::OFF_W;
	localparam int PW    = bsff_pkg::POS_W;
	localparam int LW    = bsff_pkg::LEN_W;

	bsff_pkg::req_t          req_q;
	logic [LW-1:0]           len_q;
	logic [PW-1:0]           tgt_q;
	logic [PW-1:0]           tgt_d;
	logic [bsff_pkg::NUM_WORDS-1:0] word_valid_q;
	logic                    rvalid_s1;

	logic                    re;
	logic [AW-1:0]           raddr;
	logic [WB-1:0]           rdata;
	logic [WB-1:0]           word_eff;
	logic [WB-1:0]           bit_mask;
	logic [WB-1:0]           wdata;

	logic [AW-1:0]           scan_q;
	logic                    issued_all_q;
	logic                    scan_v_s1;
	logic [AW-1:0]           scan_word_s1;
	logic                    scan_rd;
	logic [LW-1:0]           end_m1;
	logic [AW-1:0]           first_word;
	logic [AW-1:0]           last_word;
	logic [WB-1:0]           lo_mask;
	logic [WB-1:0]           hi_mask;
	logic [WB-1:0]           cand;
	logic [OW:0]             ff;
	logic                    scan_hit;

	logic [1:0]              res_status_q;
	logic                    res_read_q;
	logic                    res_found_q;
	logic [PW-1:0]           res_fpos_q;
	logic                    rsp_valid_q;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			req_q <= req;
		end
	end

	// range checks on the held request
	always_comb begin
		sts.command    = req_q.command;
		sts.pos_err    = ({1'b0, req_q.position} >= len_q);
		sts.full       = (len_q >= LW'(bsff_pkg::DEPTH_BITS));
		sts.len_err    = (req_q.new_length > LW'(bsff_pkg::DEPTH_BITS));
		sts.find_err   = sts.pos_err || (req_q.range_end > len_q)
			|| (req_q.range_end < {1'b0, req_q.position});
		sts.find_empty = (req_q.range_end == {1'b0, req_q.position});
		sts.scan_done  = scan_v_s1 && (scan_hit || (scan_word_s1 == last_word));
		sts.out_free   = !rsp_valid_q || rsp_ready;
	end

	// length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cmd.len_set) begin
			len_q <= req_q.new_length;
		end else if (cmd.len_inc) begin
			len_q <= len_q + LW'(1);
		end
	end

	// bit addressed by read, write or append
	assign tgt_d = cmd.addr_len ? len_q[PW-1:0] : req_q.position;

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			tgt_q <= tgt_d;
		end
	end

	// word ram, one read port shared by single-bit access and the scan
	assign scan_rd = cmd.scan_en && !issued_all_q;
	assign re      = cmd.rd_en || scan_rd;
	assign raddr   = scan_rd ? scan_q : tgt_d[PW-1:OW];

	bsff_ram #(
		.WIDTH (WB),
		.DEPTH (bsff_pkg::NUM_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (tgt_q[PW-1:OW]),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// a word never written since reset reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_valid_q <= '0;
			rvalid_s1    <= 1'b0;
		end else begin
			if (cmd.wr_en) begin
				word_valid_q[tgt_q[PW-1:OW]] <= 1'b1;
			end
			if (re) begin
				rvalid_s1 <= word_valid_q[raddr];
			end
		end
	end

	assign word_eff = rvalid_s1 ? rdata : '0;
	assign bit_mask = {{(WB-1){1'b0}}, 1'b1} << tgt_q[OW-1:0];
	assign wdata    = req_q.bit_value ? (word_eff | bit_mask) : (word_eff & ~bit_mask);

	// find scan: one word read per cycle, evaluated the cycle after
	assign end_m1     = req_q.range_end - LW'(1);
	assign first_word = req_q.position[PW-1:OW];
	assign last_word  = end_m1[PW-1:OW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q       <= '0;
			issued_all_q <= 1'b0;
			scan_v_s1    <= 1'b0;
			scan_word_s1 <= '0;
		end else if (cmd.scan_start) begin
			scan_q       <= first_word;
			issued_all_q <= 1'b0;
			scan_v_s1    <= 1'b0;
		end else if (scan_rd) begin
			scan_word_s1 <= scan_q;
			scan_v_s1    <= 1'b1;
			if (scan_q == last_word) begin
				issued_all_q <= 1'b1;
			end else begin
				scan_q <= scan_q + AW'(1);
			end
		end else begin
			scan_v_s1 <= 1'b0;
		end
	end

	// partial first and last words are masked to the range
	assign lo_mask = (scan_word_s1 == first_word)
		? ({WB{1'b1}} << req_q.position[OW-1:0]) : {WB{1'b1}};
	assign hi_mask = (scan_word_s1 == last_word)
		? ({WB{1'b1}} >> (OW'(WB - 1) - end_m1[OW-1:0])) : {WB{1'b1}};
	assign cand     = (req_q.bit_value ? word_eff : ~word_eff) & lo_mask & hi_mask;
	assign ff       = bsff_pkg::first_set(cand);
	assign scan_hit = ff[OW];

	// result registers
	always_ff @(posedge clk) begin
		case (cmd.res_op)
			bsff_pkg::RES_OK: begin
				res_status_q <= bsff_pkg::ST_OK;
				res_read_q   <= 1'b0;
				res_found_q  <= 1'b0;
				res_fpos_q   <= '0;
			end
			bsff_pkg::RES_RANGE: begin
				res_status_q <= bsff_pkg::ST_RANGE;
				res_read_q   <= 1'b0;
				res_found_q  <= 1'b0;
				res_fpos_q   <= '0;
			end
			bsff_pkg::RES_FULL: begin
				res_status_q <= bsff_pkg::ST_FULL;
				res_read_q   <= 1'b0;
				res_found_q  <= 1'b0;
				res_fpos_q   <= '0;
			end
			bsff_pkg::RES_READ: begin
				res_status_q <= bsff_pkg::ST_OK;
				res_read_q   <= word_eff[tgt_q[OW-1:0]];
				res_found_q  <= 1'b0;
				res_fpos_q   <= '0;
			end
			bsff_pkg::RES_FIND: begin
				res_status_q <= bsff_pkg::ST_OK;
				res_read_q   <= 1'b0;
				res_found_q  <= scan_hit;
				res_fpos_q   <= scan_hit ? {scan_word_s1, ff[OW-1:0]} : '0;
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp.status         <= res_status_q;
			rsp.read_bit       <= res_read_q;
			rsp.found          <= res_found_q;
			rsp.found_position <= res_fpos_q;
			rsp.current_length <= len_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

/* hw/rtl/bit_store_with_find_first_core.sv */
// top level of the bit store with find-first: controller plus datapath
// uses bsff_pkg, bsff_ctrl, bsff_dp (which holds bsff_ram)
//
//   channel  | handshake             | payload fields
//   ---------+-----------------------+------------------------------------------------------
//   request  | req_valid / req_ready | command, position, bit_value, range_end, new_length
//   result   | rsp_valid / rsp_ready | status, read_bit, found, found_position, current_length
//
// one request at a time; read, write and append pass decode, a ram access state and
// the result state; set length, an empty find and rejected requests go from decode
// to the result; a find reads the words its range touches, at most 64, one per cycle.
// reset clears the length and a valid bit per word, so the store reads as zero at once.
// a finished result waits in the output register; while it is not taken the next
// request is decoded and worked, then held until the output register frees up.
`default_nettype none

module bit_store_with_find_first_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output      logic           req_ready,
	input  wire bsff_pkg::req_t req,
	output      logic           rsp_valid,
	input  wire logic           rsp_ready,
	output      bsff_pkg::rsp_t rsp
);

	bsff_pkg::dp_cmd_t cmd;
	bsff_pkg::dp_sts_t sts;

	bsff_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bsff_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire

/* hw/rtl/bsff_checker.sv */
// port-level checks for the bit store with find-first, bound to the top level
// uses bsff_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module bsff_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_ready,
	input wire logic           rsp_valid,
	input wire logic           rsp_ready,
	input wire bsff_pkg::rsp_t rsp
);

	localparam int LW = bsff_pkg::LEN_W;

	logic req_acc;
	logic rsp_stall;
	logic bad_code;
	logic hit_err;

	assign req_acc   = req_valid && req_ready;
	assign rsp_stall = rsp_valid && !rsp_ready;
	assign bad_code  = (rsp.current_length > LW'(bsff_pkg::DEPTH_BITS))
		|| ((rsp.status != bsff_pkg::ST_OK) && (rsp.status != bsff_pkg::ST_RANGE)
		&& (rsp.status != bsff_pkg::ST_FULL));
	assign hit_err   = (rsp.found || rsp.read_bit) && (rsp.status != bsff_pkg::ST_OK);

	// one request in flight: no acceptance right after another
	`BSFF_ASSERT(a_one_at_a_time, clk, arst_n, req_acc |=> !req_ready, "request while busy")

	// a stalled result holds
	`BSFF_ASSERT(a_rsp_hold, clk, arst_n, rsp_stall |=> (rsp_valid && $stable(rsp)), "result moved")

	// length never beyond capacity and status always a defined code
	`BSFF_NEVER(a_rsp_range, clk, arst_n, rsp_valid && bad_code, "bad length or status code")

	// found or a read bit only come with an ok status
	`BSFF_NEVER(a_found_ok, clk, arst_n, rsp_valid && hit_err, "hit with error status")

endmodule

bind bit_store_with_find_first_core bsff_checker u_bsff_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

`default_nettype wire
